[rtl/sm3_pkg.sv]
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared constants, helper functions and controller/datapath structs
// for the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam int WordW    = 32;
    localparam int BlkWords = 16;
    localparam int Rounds   = 64;

    localparam logic [31:0] TLow  = 32'h79CC4519;
    localparam logic [31:0] THigh = 32'h7A879D8A;
    localparam logic [31:0] PadMarker = 32'h80000000;

    localparam logic [7:0][31:0] Iv = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    typedef struct packed {
        logic accept;
        logic comp_init;
        logic round;
        logic comp_end;
        logic pad;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic wc_last;
        logic wc_full;
        logic round_last;
        logic len_done;
        logic out_last;
    } t_status;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

[rtl/sm3_ctrl.sv]
// ----------------------------------------------------------------------------
// sm3_ctrl
// Sequencer: word intake, compression rounds, padding and digest output.
// ----------------------------------------------------------------------------
module sm3_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last_word,
    input  logic             i_out_ready,
    input  sm3_pkg::t_status i_status,
    output sm3_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_ROUND = 6'b000100,
        S_FIN   = 6'b001000,
        S_PAD   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_pad_active, n_pad_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pad_active <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pad_active <= n_pad_active;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_pad_active = r_pad_active;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_last_word) begin
                        n_pad_active = 1'b1;
                        n_state      = S_PAD;
                    end else if (i_status.wc_last) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.comp_init = 1'b1;
                n_state         = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_status.round_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.comp_end = 1'b1;
                if (!r_pad_active) begin
                    n_state = S_IDLE;
                end else if (i_status.len_done) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                if (i_status.wc_full) begin
                    n_state = S_LOAD;
                end else begin
                    o_cmd.pad = 1'b1;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.out_last) begin
                        n_pad_active = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/sm3_dp.sv]
// ----------------------------------------------------------------------------
// sm3_dp
// Datapath: block buffer, expansion window, round registers, chaining value,
// bit count and padding word generation.
// ----------------------------------------------------------------------------
module sm3_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sm3_pkg::t_cmd    i_cmd,
    input  logic [31:0]      i_message_word,
    input  logic [2:0]       i_valid_bytes,
    input  logic             i_last_word,
    output sm3_pkg::t_status o_status,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_digest_done
);

    logic [31:0] r_buf [sm3_pkg::BlkWords];
    logic [31:0] r_win [sm3_pkg::BlkWords];
    logic [31:0] r_r   [8];
    logic [31:0] r_v   [8];
    logic [5:0]  r_round;
    logic [4:0]  r_wc;
    logic        r_marker, n_marker;
    logic        r_len_hi;
    logic        r_len_done;
    logic [63:0] r_bits;
    logic [2:0]  r_oidx;

    logic [2:0]  nv;
    logic [31:0] in_word, pad_word, wr_word;
    logic        wr_en;
    logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2, w16;

    // byte count of incoming word; short last word masked, marker appended
    always_comb begin
        nv = 3'd4;
        if (i_last_word && i_valid_bytes < 3'd4) begin
            nv = i_valid_bytes;
        end
        unique case (nv)
            3'd0:    in_word = sm3_pkg::PadMarker;
            3'd1:    in_word = {i_message_word[31:24], 24'h800000};
            3'd2:    in_word = {i_message_word[31:16], 16'h8000};
            3'd3:    in_word = {i_message_word[31:8], 8'h80};
            default: in_word = i_message_word;
        endcase
    end

    // padding: marker if not yet written, zeros, then the two length words
    always_comb begin
        priority if (!r_marker) begin
            pad_word = sm3_pkg::PadMarker;
        end else if (r_len_hi) begin
            pad_word = r_bits[31:0];
        end else if (r_wc == 5'd14) begin
            pad_word = r_bits[63:32];
        end else begin
            pad_word = '0;
        end
    end

    assign wr_en   = i_cmd.accept || i_cmd.pad;
    assign wr_word = i_cmd.accept ? in_word : pad_word;

    // one compression round
    always_comb begin
        a12 = sm3_pkg::rotl(r_r[0], 5'd12);
        tj  = sm3_pkg::rotl((r_round[5:4] == 2'd0) ? sm3_pkg::TLow : sm3_pkg::THigh,
                            r_round[4:0]);
        ss1 = sm3_pkg::rotl(a12 + r_r[4] + tj, 5'd7);
        ss2 = ss1 ^ a12;
        if (r_round[5:4] == 2'd0) begin
            ff = r_r[0] ^ r_r[1] ^ r_r[2];
            gg = r_r[4] ^ r_r[5] ^ r_r[6];
        end else begin
            ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
            gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
        end
        tt1 = ff + r_r[3] + ss2 + (r_win[0] ^ r_win[4]);
        tt2 = gg + r_r[7] + ss1 + r_win[0];
        w16 = sm3_pkg::perm1(r_win[0] ^ r_win[7] ^ sm3_pkg::rotl(r_win[13], 5'd15))
              ^ sm3_pkg::rotl(r_win[3], 5'd7) ^ r_win[10];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[r_wc[3:0]] <= wr_word;
        end
        if (i_cmd.comp_init) begin
            for (int i = 0; i < sm3_pkg::BlkWords; i++) begin
                r_win[i] <= r_buf[i];
            end
            for (int i = 0; i < 8; i++) begin
                r_r[i] <= r_v[i];
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < sm3_pkg::BlkWords - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[sm3_pkg::BlkWords - 1] <= w16;
            r_r[0] <= tt1;
            r_r[1] <= r_r[0];
            r_r[2] <= sm3_pkg::rotl(r_r[1], 5'd9);
            r_r[3] <= r_r[2];
            r_r[4] <= sm3_pkg::perm0(tt2);
            r_r[5] <= r_r[4];
            r_r[6] <= sm3_pkg::rotl(r_r[5], 5'd19);
            r_r[7] <= r_r[6];
        end
    end

    always_comb begin
        n_marker = r_marker;
        if (i_cmd.accept) begin
            n_marker = i_last_word && (nv != 3'd4);
        end else if (i_cmd.pad) begin
            n_marker = 1'b1;
        end else if (i_cmd.emit && r_oidx == 3'd7) begin
            n_marker = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= sm3_pkg::Iv[i];
            end
            r_round    <= '0;
            r_wc       <= '0;
            r_marker   <= 1'b0;
            r_len_hi   <= 1'b0;
            r_len_done <= 1'b0;
            r_bits     <= '0;
            r_oidx     <= '0;
        end else begin
            r_marker <= n_marker;
            if (wr_en) begin
                r_wc <= r_wc + 5'd1;
            end
            if (i_cmd.accept) begin
                r_bits <= r_bits + {58'd0, nv, 3'd0};
            end
            if (i_cmd.pad && r_marker) begin
                if (r_len_hi) begin
                    r_len_done <= 1'b1;
                end else if (r_wc == 5'd14) begin
                    r_len_hi <= 1'b1;
                end
            end
            if (i_cmd.comp_init) begin
                r_round <= '0;
            end else if (i_cmd.round) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.comp_end) begin
                r_wc <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_v[i] ^ r_r[i];
                end
            end
            if (i_cmd.emit) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    // message finished: restart from the initial vector
                    for (int i = 0; i < 8; i++) begin
                        r_v[i] <= sm3_pkg::Iv[i];
                    end
                    r_bits     <= '0;
                    r_wc       <= '0;
                    r_len_hi   <= 1'b0;
                    r_len_done <= 1'b0;
                end
            end
        end
    end

    assign o_status.wc_last    = (r_wc == 5'd15);
    assign o_status.wc_full    = r_wc[4];
    assign o_status.round_last = (r_round == 6'(sm3_pkg::Rounds - 1));
    assign o_status.len_done   = r_len_done;
    assign o_status.out_last   = (r_oidx == 3'd7);

    assign o_digest_word = r_v[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_digest_done = (r_oidx == 3'd7);

endmodule

[rtl/sm3_hash_engine_top.sv]
// ----------------------------------------------------------------------------
// sm3_hash_engine_top
// SM3 hash engine: 32-bit big-endian message words in, 256-bit digest out
// as eight 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one message word per transaction;
//   i_last_word marks the final word and i_valid_bytes gives its valid leading
//   bytes (0..4, larger counts taken as 4; ignored on other words).
//   Output channel (o_valid/i_ready) returns eight transactions per message,
//   word_index 0..7, digest_done set on the eighth.
//   Intake: a non-final word is accepted in the cycle it is offered while idle,
//   and every sixteenth word starts a compression (load, 64 rounds through one
//   round unit, chaining update).
//   After the last word, padding writes one word a cycle into the block
//   buffer, compressing one or two final blocks before the first digest
//   word is shown.
//   Input is not taken while compressing, padding or emitting the digest.
//   A stalled receiver holds the current digest word; the engine waits.
//   Reset loads the initial vector and clears the count; after the eighth
//   digest word the engine reloads the initial vector itself.
// ----------------------------------------------------------------------------
module sm3_hash_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_done
);

    sm3_pkg::t_cmd    cmd;
    sm3_pkg::t_status status;

    sm3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_word (i_last_word),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid)
    );

    sm3_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_message_word (i_message_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_last_word    (i_last_word),
        .o_status       (status),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_digest_done  (o_digest_done)
    );

endmodule
